>>> rtl/drrb_pkg.sv
// Package for the DTLS record reorder buffer: sizes, status codes, cell types.
// No dependencies.
package drrb_pkg;
  localparam int unsigned Peers = 4;
  localparam int unsigned Window = 128;
  localparam int unsigned PeerW = 2;
  localparam int unsigned SlotW = 7;
  localparam int unsigned CntW = 8;
  localparam logic [7:0] MaxWindowReset = 8'd100;
  localparam logic [7:0] TypeCcs = 8'd20;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StEmpty = 3'd1;
  localparam logic [2:0] StNotReady = 3'd2;
  localparam logic [2:0] StStale = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StBadVersion = 3'd5;

  localparam logic [15:0] VerDtls10 = 16'hFEFF;
  localparam logic [15:0] VerDtls12 = 16'hFEFD;
  localparam logic [15:0] VerDtls13 = 16'hFEFC;

  // Value travelling down the chain of scan cells.
  typedef struct packed {
    logic        act;     // token is live this cycle
    logic        rel;     // release scan (else insert scan)
    logic [63:0] key;     // insert key
    logic        hit;     // insert: key match found
    logic [SlotW-1:0] hit_slot;
    logic        free;    // insert: free slot found
    logic [SlotW-1:0] free_slot;
    logic        best_v;  // release: a valid minimum found
    logic [63:0] best_key;
    logic [SlotW-1:0] best_slot;
  } scan_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
  } slot_view_t;
endpackage

>>> rtl/drrb_if.sv
// Valid/ready channel interfaces for the DTLS record reorder buffer.
// No dependencies.
interface drrb_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  peer_id;
  logic [15:0] record_version;
  logic [7:0]  record_type;
  logic [15:0] record_epoch;
  logic [47:0] record_seq;
  logic [15:0] record_handle;
  modport source (output valid, action, peer_id, record_version, record_type,
                  record_epoch, record_seq, record_handle, input ready);
  modport sink (input valid, action, peer_id, record_version, record_type,
                record_epoch, record_seq, record_handle, output ready);
endinterface

interface drrb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_epoch;
  logic [47:0] out_seq;
  logic [7:0]  out_type;
  logic [15:0] out_handle;
  modport source (output valid, status, out_epoch, out_seq, out_type, out_handle,
                  input ready);
  modport sink (input valid, status, out_epoch, out_seq, out_type, out_handle,
                output ready);
endinterface

>>> rtl/drrb_cell.sv
// One scan cell: folds one slot's view into the passing scan token.
// Depends on drrb_pkg.
module drrb_cell import drrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_t            scan_i,
  input  slot_view_t       view_i,
  input  logic [SlotW-1:0] slot_i,
  output scan_t            scan_o
);
  scan_t scan_d, scan_q;

  always_comb begin
    scan_d = scan_i;
    if (scan_i.act && view_i.valid) begin
      if (scan_i.rel) begin
        if (!scan_i.best_v || view_i.key < scan_i.best_key) begin
          scan_d.best_v = 1'b1;
          scan_d.best_key = view_i.key;
          scan_d.best_slot = slot_i;
        end
      end else if (!scan_i.hit && view_i.key == scan_i.key) begin
        scan_d.hit = 1'b1;
        scan_d.hit_slot = slot_i;
      end
    end else if (scan_i.act && !scan_i.rel && !scan_i.free) begin
      scan_d.free = 1'b1;
      scan_d.free_slot = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;
endmodule

>>> rtl/drrb_chain.sv
// Chain of two scan cells sweeping a peer window, two slots per cycle.
// Depends on drrb_pkg and drrb_cell.
module drrb_chain import drrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_t            scan_i,
  input  slot_view_t       view_a_i,
  input  slot_view_t       view_b_i,
  input  logic [SlotW-1:0] slot_a_i,
  output scan_t            scan_o
);
  scan_t mid;
  drrb_cell u_cell_a (.clk_i, .rst_ni, .scan_i(scan_i), .view_i(view_a_i),
                      .slot_i(slot_a_i), .scan_o(mid));
  logic [SlotW-1:0] slot_b_q;
  slot_view_t view_b_q;
  always_ff @(posedge clk_i) begin
    slot_b_q <= slot_a_i + SlotW'(1);
    view_b_q <= view_b_i;
  end
  drrb_cell u_cell_b (.clk_i, .rst_ni, .scan_i(mid), .view_i(view_b_q),
                      .slot_i(slot_b_q), .scan_o(scan_o));
endmodule

>>> rtl/dtls_record_reorder_buffer.sv
// DTLS record reorder buffer, top level.
// Valid/ready input and output channels, APB-style max_window register.
// Each accepted transfer yields exactly one result transfer. Insert carries
// peer, version, type, epoch, 48-bit sequence and handle; release returns the
// in-order record of the peer or a status (empty, not ready).
// Records live in a memory of Peers*Window entries; slot valid bits are flops
// cleared at reset, so no clearing pass is needed.
// A transfer walks the peer window through a chain of two scan cells fed from
// two memory read ports, two slots per cycle, folding each pair into a
// running result; the scan is followed by a drain, a fetch and a write-back
// state, and the result register is loaded at write-back. A new item is
// taken only after the previous one has been written back.
// Input ready is high only when no item is in work. A result that waits in
// the output register does not block the next input transfer; that item
// scans and then holds before its write-back until the result register is
// taken. Reset empties every window, zeroes the per-peer expectation and sets
// max_window to 100.
// Depends on drrb_pkg, drrb_if, drrb_cell, drrb_chain.
module dtls_record_reorder_buffer import drrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  drrb_in_if.sink     in_if,
  drrb_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SDrain = 3'd2;
  localparam logic [2:0] SFetch = 3'd3;
  localparam logic [2:0] SDone = 3'd4;
  localparam int unsigned AddrW = PeerW + SlotW;
  localparam int unsigned DrainN = 3;

  logic [7:0] max_window_q;
  logic [2:0] state_q, state_d;
  logic [SlotW:0] rd_cnt_q;
  logic [1:0] drain_q;
  logic rel_q, rd_v_q;
  logic [PeerW-1:0] peer_q;
  logic [7:0] type_q;
  logic [15:0] epoch_q, handle_q;
  logic [47:0] seq_q;
  logic [2:0] st_q;
  logic [15:0] oe_q, oh_q;
  logic [47:0] os_q;
  logic [7:0] ot_q;
  logic ov_q;

  logic [15:0] exp_epoch_q [Peers];
  logic [47:0] exp_seq_q [Peers];
  logic [CntW-1:0] count_q [Peers];
  logic [Peers*Window-1:0] valid_q;

  logic [63:0] mem_key [Peers*Window];
  logic [23:0] mem_dat [Peers*Window];
  logic [63:0] rk_a_q, rk_b_q;
  logic [23:0] rdat_q;
  logic [SlotW-1:0] rslot_q;
  logic va_q, vb_q;

  assign pready = 1'b1;
  assign prdata = {24'd0, max_window_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_window_q <= MaxWindowReset;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      max_window_q <= pwdata[7:0];
    end
  end

  logic in_fire;
  logic out_fire;
  assign in_fire = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = (state_q == SIdle);

  // scan token
  scan_t tok_in, tok_out, tok_q, tok_acc;
  logic [63:0] key_in;
  assign key_in = {epoch_q, seq_q};
  always_comb begin
    tok_in = '0;
    tok_in.act = rd_v_q;
    tok_in.rel = rel_q;
    tok_in.key = key_in;
  end
  logic [SlotW-1:0] slot_a;
  assign slot_a = rslot_q;
  slot_view_t view_a, view_b;
  assign view_a.valid = va_q;
  assign view_a.key = rk_a_q;
  assign view_b.valid = vb_q;
  assign view_b.key = rk_b_q;
  drrb_chain u_chain (.clk_i, .rst_ni, .scan_i(tok_in),
    .view_a_i(view_a), .view_b_i(view_b),
    .slot_a_i(slot_a), .scan_o(tok_out));

  // fold each slot pair into the running window result, lowest slot first
  always_comb begin
    tok_acc = tok_q;
    if (!tok_q.hit && tok_out.hit) begin
      tok_acc.hit = 1'b1;
      tok_acc.hit_slot = tok_out.hit_slot;
    end
    if (!tok_q.free && tok_out.free) begin
      tok_acc.free = 1'b1;
      tok_acc.free_slot = tok_out.free_slot;
    end
    if (tok_out.best_v && (!tok_q.best_v || tok_out.best_key < tok_q.best_key)) begin
      tok_acc.best_v = 1'b1;
      tok_acc.best_key = tok_out.best_key;
      tok_acc.best_slot = tok_out.best_slot;
    end
  end

  // memory reads, two slots per cycle
  logic [AddrW-1:0] ra, rb;
  logic rd_en;
  assign rd_en = (state_q == SScan);
  assign ra = {peer_q, rd_cnt_q[SlotW-1:0]};
  assign rb = {peer_q, rd_cnt_q[SlotW-1:0] + SlotW'(1)};
  logic [AddrW-1:0] fa;
  assign fa = {peer_q, tok_q.best_slot};
  always_ff @(posedge clk_i) begin
    rk_a_q <= mem_key[ra];
    rk_b_q <= mem_key[rb];
    rdat_q <= mem_dat[fa];
    rslot_q <= rd_cnt_q[SlotW-1:0];
    va_q <= valid_q[ra];
    vb_q <= valid_q[rb] && (Window > 1);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else rd_v_q <= rd_en;
  end

  logic [63:0] exp_key;
  assign exp_key = {exp_epoch_q[peer_q], exp_seq_q[peer_q]};
  logic [7:0] limit;
  assign limit = (max_window_q < 8'(Window)) ? max_window_q : 8'(Window);

  logic [15:0] ver_q;
  logic wr_en;
  logic [AddrW-1:0] wa;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_fire) state_d = SScan;
      SScan: if (rd_cnt_q >= (SlotW+1)'(Window - 2) || Window < 3) state_d = SDrain;
      SDrain: if (drain_q == 2'(DrainN - 1)) state_d = SFetch;
      SFetch: if (!ov_q || out_fire) state_d = SDone;
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rel_q <= in_if.action;
      peer_q <= in_if.peer_id;
      ver_q <= in_if.record_version;
      type_q <= in_if.record_type;
      epoch_q <= in_if.record_epoch;
      seq_q <= in_if.record_seq;
      handle_q <= in_if.record_handle;
    end
    if (state_q == SIdle) tok_q <= '0;
    else if (tok_out.act) tok_q <= tok_acc;
    if (wr_en) begin
      mem_key[wa] <= key_in;
      mem_dat[wa] <= {type_q, handle_q};
    end
  end

  logic good_ver;
  assign good_ver = ver_q == VerDtls10 || ver_q == VerDtls12 || ver_q == VerDtls13;
  logic ins_slot_ok;
  assign ins_slot_ok = tok_q.hit || tok_q.free;
  assign wr_en = (state_q == SDone) && !rel_q && good_ver && !(key_in < exp_key)
                 && (count_q[peer_q] < limit) && ins_slot_ok;
  assign wa = {peer_q, tok_q.hit ? tok_q.hit_slot : tok_q.free_slot};
  logic rel_ok;
  assign rel_ok = (state_q == SDone) && rel_q && tok_q.best_v && tok_q.best_key == exp_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rd_cnt_q <= '0;
      drain_q <= '0;
      ov_q <= 1'b0;
      valid_q <= '0;
      for (int p = 0; p < Peers; p++) begin
        exp_epoch_q[p] <= '0;
        exp_seq_q[p] <= '0;
        count_q[p] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_fire && state_q != SDone) ov_q <= 1'b0;
      case (state_q)
        SIdle: begin
          rd_cnt_q <= '0;
          drain_q <= '0;
        end
        SScan: rd_cnt_q <= rd_cnt_q + (SlotW+1)'(2);
        SDrain: drain_q <= drain_q + 2'd1;
        SDone: begin
          ov_q <= 1'b1;
          if (wr_en) begin
            valid_q[wa] <= 1'b1;
            if (!tok_q.hit) count_q[peer_q] <= count_q[peer_q] + CntW'(1);
          end
          if (rel_ok) begin
            valid_q[{peer_q, tok_q.best_slot}] <= 1'b0;
            if (count_q[peer_q] != '0) count_q[peer_q] <= count_q[peer_q] - CntW'(1);
            if (rdat_q[23:16] == TypeCcs) begin
              exp_epoch_q[peer_q] <= tok_q.best_key[63:48] + 16'd1;
              exp_seq_q[peer_q] <= '0;
            end else begin
              exp_seq_q[peer_q] <= tok_q.best_key[47:0] + 48'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SDone) begin
      oe_q <= '0; os_q <= '0; ot_q <= '0; oh_q <= '0;
      if (rel_q) begin
        if (!tok_q.best_v) st_q <= StEmpty;
        else if (!rel_ok) st_q <= StNotReady;
        else begin
          st_q <= StOk;
          oe_q <= tok_q.best_key[63:48];
          os_q <= tok_q.best_key[47:0];
          ot_q <= rdat_q[23:16];
          oh_q <= rdat_q[15:0];
        end
      end else if (!good_ver) st_q <= StBadVersion;
      else if (key_in < exp_key) st_q <= StStale;
      else if (!wr_en) st_q <= StFull;
      else st_q <= StOk;
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.status = st_q;
  assign out_if.out_epoch = oe_q;
  assign out_if.out_seq = os_q;
  assign out_if.out_type = ot_q;
  assign out_if.out_handle = oh_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == SIdle) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |=> ov_q) else $error("result not posted");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rel_ok)) else $error("write and release together");
  a_count_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> count_q[peer_q] <= CntW'(Window)) else $error("count overflow");
endmodule

>>> verif/dtls_record_reorder_buffer_test.sv
// Testbench for the DTLS record reorder buffer: random and directed record
// inserts/releases against an in-bench per-peer reorder predictor.
// Depends on drrb_pkg, drrb_if and the dtls_record_reorder_buffer RTL.
`timescale 1ns / 1ps

module dtls_record_reorder_buffer_test;
  import drrb_pkg::*;

  typedef struct packed {
    logic        action;
    logic [1:0]  peer_id;
    logic [15:0] version;
    logic [7:0]  rtype;
    logic [15:0] epoch;
    logic [47:0] seq;
    logic [15:0] handle;
  } record_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] epoch;
    logic [47:0] seq;
    logic [7:0]  rtype;
    logic [15:0] handle;
  } release_rsp_t;

  localparam logic ActInsert = 1'b0;
  localparam logic ActRelease = 1'b1;
  localparam logic [2:0] RegMaxWindow = 3'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  drrb_in_if in_if ();
  drrb_out_if out_if ();

  dtls_record_reorder_buffer i_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  win_limit;
  logic [15:0] next_epoch [Peers];
  logic [47:0] next_seq [Peers];
  int unsigned held [Peers];
  logic        sv [Peers][Window];
  logic [63:0] skey [Peers][Window];
  logic [7:0]  stype [Peers][Window];
  logic [15:0] shandle [Peers][Window];

  record_req_t  pending_reqs[$];
  release_rsp_t expected_rsps[$];
  int unsigned  mismatches = 0;
  int unsigned  checked = 0;
  int unsigned  released_ok = 0;
  int unsigned  long_stall = 0;
  bit           out_rdy_en = 1'b1;
  int unsigned  burst_left = 0, gap_left = 0;

  function automatic release_rsp_t predict_record(record_req_t r);
    release_rsp_t o;
    int unsigned p, lim, slot;
    logic [63:0] key, nxt, best;
    int best_s;
    o = '0;
    p = r.peer_id;
    nxt = {next_epoch[p], next_seq[p]};
    if (r.action == ActInsert) begin
      key = {r.epoch, r.seq};
      lim = (win_limit < Window) ? win_limit : Window;
      if (!(r.version inside {VerDtls10, VerDtls12, VerDtls13})) o.status = StBadVersion;
      else if (key < nxt) o.status = StStale;
      else if (held[p] >= lim) o.status = StFull;
      else begin
        slot = Window;
        for (int i = 0; i < Window; i++)
          if (slot == Window && sv[p][i] && skey[p][i] == key) slot = i;
        if (slot == Window) begin
          for (int i = 0; i < Window; i++)
            if (slot == Window && !sv[p][i]) slot = i;
          held[p]++;
        end
        sv[p][slot] = 1'b1;
        skey[p][slot] = key;
        stype[p][slot] = r.rtype;
        shandle[p][slot] = r.handle;
        o.status = StOk;
      end
    end else begin
      best_s = -1;
      best = '0;
      for (int i = 0; i < Window; i++)
        if (sv[p][i] && (best_s < 0 || skey[p][i] < best)) begin
          best_s = i;
          best = skey[p][i];
        end
      if (best_s < 0) o.status = StEmpty;
      else if (best != nxt) o.status = StNotReady;
      else begin
        o.status = StOk;
        o.epoch = best[63:48];
        o.seq = best[47:0];
        o.rtype = stype[p][best_s];
        o.handle = shandle[p][best_s];
        if (o.rtype == TypeCcs) begin
          next_epoch[p] = o.epoch + 16'd1;
          next_seq[p] = '0;
        end else begin
          next_epoch[p] = o.epoch;
          next_seq[p] = o.seq + 48'd1;
        end
        sv[p][best_s] = 1'b0;
        if (held[p] > 0) held[p]--;
      end
    end
    return o;
  endfunction

  // driver: bursts with gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_rsps.push_back(predict_record(pending_reqs.pop_front()));
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          {in_if.action, in_if.peer_id, in_if.record_version, in_if.record_type,
           in_if.record_epoch, in_if.record_seq, in_if.record_handle} <= pending_reqs[0];
          in_if.valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= out_rdy_en && ($urandom_range(0, 7) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    release_rsp_t got, exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.status, out_if.out_epoch, out_if.out_seq, out_if.out_type,
             out_if.out_handle};
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp = expected_rsps.pop_front();
        checked++;
        if (got.status == StOk && exp.rtype != 0) released_ok++;
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d ep=%h sq=%h ty=%h h=%h got st=%0d ep=%h sq=%h ty=%h h=%h",
                     exp.status, exp.epoch, exp.seq, exp.rtype, exp.handle,
                     got.status, got.epoch, got.seq, got.rtype, got.handle);
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == RegMaxWindow) win_limit = data[7:0];
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic record_req_t mk(logic act, logic [1:0] p, logic [15:0] ver,
                                     logic [7:0] ty, logic [15:0] ep, logic [47:0] sq);
    record_req_t r;
    r = '{act, p, ver, ty, ep, sq, 16'($urandom)};
    return r;
  endfunction

  function automatic logic [15:0] rnd_version();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return VerDtls10;
      2: return VerDtls13;
      default: return VerDtls12;
    endcase
  endfunction

  // well-formed in-order-ish stream per peer over random peers plus noise
  task automatic queue_phase(int unsigned n);
    logic [15:0] ep [Peers];
    logic [47:0] sq [Peers];
    logic [1:0] p;
    record_req_t r;
    for (int i = 0; i < Peers; i++) begin
      ep[i] = next_epoch[i];
      sq[i] = next_seq[i] + held[i];
    end
    for (int i = 0; i < n; i++) begin
      p = 2'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r = mk(ActInsert, p, rnd_version(), ($urandom_range(0, 15) == 0) ? TypeCcs :
                 8'($urandom), ep[p], sq[p] + $urandom_range(0, 3));
          if (r.rtype == TypeCcs && r.seq == sq[p]) begin
            ep[p]++;
            sq[p] = 0;
          end else if (r.seq == sq[p]) begin
            sq[p]++;
          end
        end
        4, 5, 6, 7: r = mk(ActRelease, p, 16'($urandom), 8'($urandom), 16'($urandom),
                           48'({$urandom, $urandom}));
        8: r = mk(ActInsert, p, rnd_version(), 8'($urandom), 16'($urandom),
                  48'({$urandom, $urandom}));
        default: r = mk(ActInsert, p, rnd_version(), 8'($urandom), ep[p],
                        sq[p] - $urandom_range(1, 4));
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    win_limit = MaxWindowReset;
    for (int i = 0; i < Peers; i++) begin
      next_epoch[i] = '0;
      next_seq[i] = '0;
      held[i] = 0;
      for (int j = 0; j < Window; j++) sv[i][j] = 1'b0;
    end
    in_if.action = 1'b0; in_if.peer_id = '0; in_if.record_version = '0;
    in_if.record_type = '0; in_if.record_epoch = '0; in_if.record_seq = '0;
    in_if.record_handle = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty, bad version, ordering, overwrite, ccs, wraps, stale
    pending_reqs.push_back(mk(ActRelease, 2'd0, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, 16'hFEFE, 8'd23, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, 16'hFFFF, 8'd23, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, VerDtls12, 8'd23, 16'h0, 48'h1));
    pending_reqs.push_back(mk(ActRelease, 2'd0, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, VerDtls10, 8'hFF, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, VerDtls10, 8'd22, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActRelease, 2'd0, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, VerDtls13, TypeCcs, 16'h0, 48'h1));
    pending_reqs.push_back(mk(ActRelease, 2'd0, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd0, VerDtls12, 8'd23, 16'h0, 48'h5));
    pending_reqs.push_back(mk(ActInsert, 2'd1, VerDtls12, 8'd23, 16'h0, 48'hFFFF_FFFF_FFFF));
    pending_reqs.push_back(mk(ActInsert, 2'd1, VerDtls12, TypeCcs, 16'hFFFF,
                              48'hFFFF_FFFF_FFFF));
    pending_reqs.push_back(mk(ActRelease, 2'd1, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActRelease, 2'd3, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActInsert, 2'd3, VerDtls12, 8'd23, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActRelease, 2'd3, 16'h0, 8'h0, 16'h0, 48'h0));
    pending_reqs.push_back(mk(ActRelease, 2'd1, 16'h0, 8'h0, 16'h0, 48'h0));
    wait_drained();

    // window 1: overflow, long receiver hold-off fills the pipe
    apb_write(RegMaxWindow, 32'd1);
    pending_reqs.push_back(mk(ActInsert, 2'd2, VerDtls12, 8'd23, 16'h0, 48'h3));
    pending_reqs.push_back(mk(ActInsert, 2'd2, VerDtls12, 8'd23, 16'h0, 48'h3));
    pending_reqs.push_back(mk(ActInsert, 2'd2, VerDtls12, 8'd23, 16'h0, 48'h4));
    long_stall = 2000;
    queue_phase(200);
    wait_drained();

    apb_write(RegMaxWindow, 32'd0);
    queue_phase(150);
    wait_drained();
    apb_write(RegMaxWindow, 32'd128);
    queue_phase(200);
    wait_drained();
    apb_write(RegMaxWindow, 32'd255);
    queue_phase(350);
    wait_drained();
    apb_write(RegMaxWindow, 32'd4);
    queue_phase(300);
    wait_drained();
    apb_write(RegMaxWindow, 32'd100);
    queue_phase(300);
    wait_drained();

    $display("Checked %0d results (%0d in-order releases) over window limits 0..255.",
             checked, released_ok);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd100 * 64'd1_000_000);
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end
endmodule

>>> files.f
rtl/drrb_pkg.sv
rtl/drrb_if.sv
rtl/drrb_cell.sv
rtl/drrb_chain.sv
rtl/dtls_record_reorder_buffer.sv
verif/dtls_record_reorder_buffer_test.sv
